[rtl/pets_pkg.sv]
package pets_pkg;

  // default slot count and the limit that the 4-bit task ids impose
  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned IdLimit     = 16;

  localparam int unsigned KindW   = 3;
  localparam int unsigned IdW     = 4;
  localparam int unsigned EventW  = 16;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned StatusW = 2;

  typedef enum logic [KindW-1:0] {
    KindAdd   = 3'd0,
    KindSet   = 3'd1,
    KindClear = 3'd2,
    KindGet   = 3'd3,
    KindPoll  = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    StOk   = 2'd0,
    StFull = 2'd1,
    StNone = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StModify,
    StScan,
    StTake,
    StResp
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IdW-1:0]    task_id;
    logic [EventW-1:0] event_mask;
    logic [PrioW-1:0]  priority_req;
    logic              has_handler;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     result_task;
    logic [EventW-1:0]  result_events;
    logic               dispatch;
  } result_t;

endpackage

[rtl/pets_in_if.sv]
interface pets_in_if
  import pets_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/pets_out_if.sv]
interface pets_out_if
  import pets_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/priority_event_task_scheduler.sv]
// Sequence: add, unknown-id, unused-kind and empty-table poll go from StIdle
// to StResp; set/clear/get pass through StModify; poll on a non-empty table
// scans in StScan (one slot per cycle through the single read port of the
// slot memories), then goes through StTake to StResp.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register, which waits while an unaccepted result is held.
// Reset: asynchronous, clears control state and the task count; no clearing pass.
module priority_event_task_scheduler
  import pets_pkg::*;
#(
  parameter int unsigned MaxTasks = MaxTasksDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pets_in_if.sink    in_i,
  pets_out_if.source out_o
);

  localparam int unsigned Depth = (MaxTasks < IdLimit) ? MaxTasks : IdLimit;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SlotW = PrioW + 1;

  state_e              state_q, state_d;
  item_t               item_q, item_d;
  result_t             res_q, res_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     scan_q, scan_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     best_q, best_d;
  logic [PrioW-1:0]    best_pri_q, best_pri_d;
  logic [EventW-1:0]   best_ev_q, best_ev_d;
  logic                best_hnd_q, best_hnd_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;

  // memory ports
  logic                slot_we, pend_we;
  logic [IdxW-1:0]     slot_waddr, pend_waddr, raddr;
  logic [SlotW-1:0]    slot_wdata, slot_rdata;
  logic [EventW-1:0]   pend_wdata, pend_rdata;

  logic                accept, known, scan_last, better;
  logic [PrioW-1:0]    rd_pri;

  pets_ram #(.Width(SlotW), .Depth(Depth)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (raddr),
    .rdata_o (slot_rdata)
  );

  pets_ram #(.Width(EventW), .Depth(Depth)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (raddr),
    .rdata_o (pend_rdata)
  );

  assign in_i.ready    = (state_q == StIdle);
  assign accept        = in_i.valid && (state_q == StIdle);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // slot lookups
  assign known     = ({1'b0, in_i.payload.task_id} < (IdW + 1)'(cnt_q));
  assign scan_last = ((CntW'(scan_q) + CntW'(1)) == cnt_q);
  assign rd_pri    = slot_rdata[SlotW-1:1];
  assign better    = (pend_rdata != '0) && (!found_q || (rd_pri > best_pri_q));

  // sequencer: decode, read-modify-write and poll scan
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    scan_d     = scan_q;
    found_d    = found_q;
    best_d     = best_q;
    best_pri_d = best_pri_q;
    best_ev_d  = best_ev_q;
    best_hnd_d = best_hnd_q;
    slot_we    = 1'b0;
    slot_waddr = cnt_q[IdxW-1:0];
    slot_wdata = {in_i.payload.priority_req, in_i.payload.has_handler};
    pend_we    = 1'b0;
    pend_waddr = cnt_q[IdxW-1:0];
    pend_wdata = '0;
    raddr      = in_i.payload.task_id[IdxW-1:0];

    case (state_q)
      StIdle: begin
        if (accept) begin
          item_d  = in_i.payload;
          res_d   = '0;
          state_d = StResp;
          case (in_i.payload.kind)
            KindAdd: begin
              if (cnt_q >= CntW'(Depth)) begin
                res_d.status = StFull;
              end else begin
                slot_we           = 1'b1;
                pend_we           = 1'b1;
                res_d.status      = StOk;
                res_d.result_task = IdW'(cnt_q);
                cnt_d             = cnt_q + CntW'(1);
              end
            end
            KindSet, KindClear, KindGet: begin
              if (known) begin
                state_d = StModify;
              end else begin
                res_d.status = StNone;
              end
            end
            KindPoll: begin
              raddr   = '0;
              scan_d  = '0;
              found_d = 1'b0;
              if (cnt_q != '0) begin
                state_d = StScan;
              end else begin
                res_d.status = StNone;
              end
            end
            default: begin
              res_d.status = StNone;
            end
          endcase
        end
      end

      StModify: begin
        pend_waddr   = item_q.task_id[IdxW-1:0];
        res_d.status = StOk;
        case (item_q.kind)
          KindSet: begin
            pend_we    = 1'b1;
            pend_wdata = pend_rdata | item_q.event_mask;
          end
          KindClear: begin
            pend_we    = 1'b1;
            pend_wdata = pend_rdata & ~item_q.event_mask;
          end
          default: begin
            res_d.result_events = pend_rdata;
          end
        endcase
        state_d = StResp;
      end

      StScan: begin
        // read data belongs to slot scan_q, next slot is fetched meanwhile
        raddr = scan_q + IdxW'(1);
        if (better) begin
          found_d    = 1'b1;
          best_d     = scan_q;
          best_pri_d = rd_pri;
          best_ev_d  = pend_rdata;
          best_hnd_d = slot_rdata[0];
        end
        scan_d = scan_q + IdxW'(1);
        if (scan_last) begin
          state_d = StTake;
        end
      end

      StTake: begin
        res_d = '0;
        if (found_q) begin
          pend_we             = 1'b1;
          pend_waddr          = best_q;
          res_d.status        = StOk;
          res_d.result_task   = IdW'(best_q);
          res_d.result_events = best_ev_q;
          res_d.dispatch      = best_hnd_q;
        end else begin
          res_d.status = StNone;
        end
        state_d = StResp;
      end

      StResp: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == StResp) && (!out_valid_q || out_o.ready)) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    scan_q     <= scan_d;
    best_q     <= best_d;
    best_pri_q <= best_pri_d;
    best_ev_q  <= best_ev_d;
    best_hnd_q <= best_hnd_d;
    out_q      <= out_d;
  end

endmodule

[rtl/pets_ram.sv]
module pets_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
